/* hw/rtl/rotated_sorted_array_search_defines.svh */
// assertion macros for the rotated sorted array search block
`ifndef ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RSAS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rsas assertion failed");

// next-cycle implication, disabled while reset is low
`define RSAS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rsas assertion failed");

`endif

/* hw/rtl/rsas_pkg.sv */
`default_nettype none
package rsas_pkg;

    localparam int IDX_W = 10;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] element_value;
        logic signed [31:0] search_key;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] found_index;
    } t_out_beat;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_LAST,
        RD_MID,
        RD_PREV,
        RD_NEXT,
        RD_LOW
    } t_rd_sel;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_LAST,
        CAP_CUR,
        CAP_PREV,
        CAP_NEXT
    } t_cap;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_PTEST,
        OP_PDEC,
        OP_PART,
        OP_BTEST,
        OP_BCMP
    } t_op;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_INIT  = 4'd0;
    localparam t_pc PC_LAST  = 4'd1;
    localparam t_pc PC_PTEST = 4'd2;
    localparam t_pc PC_PREV  = 4'd3;
    localparam t_pc PC_NEXT  = 4'd4;
    localparam t_pc PC_LOW   = 4'd5;
    localparam t_pc PC_PDEC  = 4'd6;
    localparam t_pc PC_PART  = 4'd7;
    localparam t_pc PC_BTEST = 4'd8;
    localparam t_pc PC_BCMP  = 4'd9;

    typedef struct packed {
        t_rd_sel rd;
        t_cap    cap;
        t_op     op;
        t_pc     pc_t;
        t_pc     pc_f;
    } t_uword;

    // control store: pc_t taken when the step's condition holds, pc_f otherwise
    function automatic t_uword ucode_word(input t_pc pc);
        t_uword w;
        case (pc)
            PC_INIT:  w = '{RD_LAST, CAP_NONE, OP_INIT,  PC_INIT,  PC_LAST};
            PC_LAST:  w = '{RD_NONE, CAP_LAST, OP_NONE,  PC_PTEST, PC_PTEST};
            PC_PTEST: w = '{RD_MID,  CAP_NONE, OP_PTEST, PC_PART,  PC_PREV};
            PC_PREV:  w = '{RD_PREV, CAP_CUR,  OP_NONE,  PC_NEXT,  PC_NEXT};
            PC_NEXT:  w = '{RD_NEXT, CAP_PREV, OP_NONE,  PC_LOW,   PC_LOW};
            PC_LOW:   w = '{RD_LOW,  CAP_NEXT, OP_NONE,  PC_PDEC,  PC_PDEC};
            PC_PDEC:  w = '{RD_NONE, CAP_NONE, OP_PDEC,  PC_PART,  PC_PTEST};
            PC_PART:  w = '{RD_NONE, CAP_NONE, OP_PART,  PC_INIT,  PC_BTEST};
            PC_BTEST: w = '{RD_MID,  CAP_NONE, OP_BTEST, PC_INIT,  PC_BCMP};
            PC_BCMP:  w = '{RD_NONE, CAP_NONE, OP_BCMP,  PC_INIT,  PC_BTEST};
            default:  w = '{RD_NONE, CAP_NONE, OP_NONE,  PC_INIT,  PC_INIT};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rsas_ram.sv */
`default_nettype none
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/rotated_sorted_array_search.sv */
// append and clear: accepted whenever no search is busy, no result beat
// search: reads the last element, probes mid, its wrapping neighbours and low for the pivot,
// then bisects the half that can hold the key; the single store read port serialises the probes
// one search in flight; the next beat is taken while the previous result waits
// reset empties the store (count to zero); store contents stay undefined, no clearing pass
`default_nettype none
`include "rotated_sorted_array_search_defines.svh"
module rotated_sorted_array_search
    import rsas_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    localparam int AW = $clog2(STORE_DEPTH),
    localparam int CW = $clog2(STORE_DEPTH + 1)
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    localparam logic signed [CW:0] ONE_S = 1;

    logic                 r_busy, n_busy;
    t_pc                  r_pc, n_pc;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;
    logic signed [CW:0]   r_low, n_low;
    logic signed [CW:0]   r_high, n_high;
    logic [AW-1:0]        r_mid, n_mid;
    logic [AW-1:0]        r_pivot, n_pivot;
    logic signed [31:0]   r_key, n_key;
    logic signed [31:0]   r_last, n_last;
    logic signed [31:0]   r_cur, n_cur;
    logic signed [31:0]   r_prev, n_prev;
    logic signed [31:0]   r_next, n_next;

    t_uword               uw;
    logic                 in_acc;
    logic                 cond;
    logic                 fin;
    logic                 hold;
    logic [1:0]           fin_status;
    logic [AW-1:0]        fin_idx;
    logic [AW+IDX_W-1:0]  idx_ext;
    logic signed [CW:0]   count_s;
    logic signed [CW:0]   nm1;
    logic [CW+1:0]        mid_sum;
    logic [CW:0]          mid_c;
    logic signed [CW:0]   mid_ext;
    logic signed [CW:0]   pivot_ext;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic signed [31:0]   rdata;
    logic [31:0]          ram_rdata;

    assign uw         = ucode_word(r_pc);
    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
    assign rdata       = $signed(ram_rdata);

    assign count_s   = $signed({1'b0, r_count});
    assign nm1       = count_s - ONE_S;
    assign mid_sum   = {1'b0, r_low} + {1'b0, r_high};
    assign mid_c     = mid_sum[CW+1:1];
    assign mid_ext   = $signed({{(CW+1-AW){1'b0}}, r_mid});
    assign pivot_ext = $signed({{(CW+1-AW){1'b0}}, r_pivot});
    assign ram_we    = in_acc && (i_in_beat.command == CMD_APPEND)
                       && (r_count != CW'(STORE_DEPTH));

    // read address for this step
    always_comb begin
        ram_raddr = '0;
        case (uw.rd)
            RD_LAST: ram_raddr = nm1[AW-1:0];
            RD_MID:  ram_raddr = mid_c[AW-1:0];
            RD_PREV: ram_raddr = (r_mid == '0) ? nm1[AW-1:0] : r_mid - 1'b1;
            RD_NEXT: ram_raddr = (mid_ext == nm1) ? '0 : r_mid + 1'b1;
            RD_LOW:  ram_raddr = r_low[AW-1:0];
            default: ram_raddr = '0;
        endcase
    end

    assign ram_re = r_busy && (uw.rd != RD_NONE) && !hold;

    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_low       = r_low;
        n_high      = r_high;
        n_mid       = r_mid;
        n_pivot     = r_pivot;
        n_key       = r_key;
        n_last      = r_last;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_next      = r_next;
        cond        = 1'b0;
        fin         = 1'b0;
        fin_status  = ST_NOT_FOUND;
        fin_idx     = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (in_acc) begin
            case (i_in_beat.command)
                CMD_APPEND: begin
                    if (ram_we) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_CLEAR: n_count = '0;
                CMD_SEARCH: begin
                    n_busy = 1'b1;
                    n_pc   = PC_INIT;
                    n_key  = i_in_beat.search_key;
                end
                default: ;
            endcase
        end

        if (r_busy) begin
            case (uw.cap)
                CAP_LAST: n_last = rdata;
                CAP_CUR:  n_cur  = rdata;
                CAP_PREV: n_prev = rdata;
                CAP_NEXT: n_next = rdata;
                default: ;
            endcase

            case (uw.op)
                OP_INIT: begin
                    cond = (r_count == '0);
                    if (cond) begin
                        fin        = 1'b1;
                        fin_status = ST_EMPTY;
                    end else begin
                        n_low  = '0;
                        n_high = nm1;
                    end
                end
                OP_PTEST: begin
                    cond = (r_low > r_high);
                    if (cond) begin
                        n_pivot = '0;
                    end else begin
                        n_mid = mid_c[AW-1:0];
                    end
                end
                OP_PDEC: begin
                    cond = (r_cur < r_prev) && (r_cur < r_next);
                    if (cond) begin
                        n_pivot = r_mid;
                    end else if (r_cur >= rdata) begin
                        n_low = mid_ext + ONE_S;
                    end else begin
                        n_high = mid_ext - ONE_S;
                    end
                end
                OP_PART: begin
                    cond = (r_last == r_key);
                    if (cond) begin
                        fin        = 1'b1;
                        fin_status = ST_FOUND;
                        fin_idx    = nm1[AW-1:0];
                    end else if (r_last > r_key) begin
                        n_low  = pivot_ext;
                        n_high = nm1;
                    end else begin
                        n_low  = '0;
                        n_high = pivot_ext - ONE_S;
                    end
                end
                OP_BTEST: begin
                    cond = (r_low > r_high);
                    if (cond) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_FOUND;
                    end else begin
                        n_mid = mid_c[AW-1:0];
                    end
                end
                OP_BCMP: begin
                    cond = (rdata == r_key);
                    if (cond) begin
                        fin        = 1'b1;
                        fin_status = ST_FOUND;
                        fin_idx    = r_mid;
                    end else if (rdata < r_key) begin
                        n_low = mid_ext + ONE_S;
                    end else begin
                        n_high = mid_ext - ONE_S;
                    end
                end
                default: ;
            endcase

            n_pc = cond ? uw.pc_t : uw.pc_f;
            if (fin) begin
                if (r_out_valid && !i_out_ready) begin
                    n_pc = r_pc;
                end else begin
                    n_busy                = 1'b0;
                    n_out_valid           = 1'b1;
                    n_out.status          = fin_status;
                    n_out.found_index     = (fin_status == ST_FOUND)
                                            ? idx_ext[IDX_W-1:0] : '0;
                end
            end
        end
    end

    assign hold    = fin && r_out_valid && !i_out_ready;
    assign idx_ext = {{IDX_W{1'b0}}, fin_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_INIT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pc        <= n_pc;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_low   <= n_low;
        r_high  <= n_high;
        r_mid   <= n_mid;
        r_pivot <= n_pivot;
        r_key   <= n_key;
        r_last  <= n_last;
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_next  <= n_next;
    end

    rsas_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_beat.element_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    `RSAS_ASSERT_NXT(a_search_starts, i_clk, i_rst_n, in_acc && (i_in_beat.command == CMD_SEARCH), r_busy)
    `RSAS_ASSERT_NXT(a_append_counts, i_clk, i_rst_n, ram_we, r_count == CW'($past(r_count) + 1'b1))
    `RSAS_ASSERT_IMP(a_probe_in_range, i_clk, i_rst_n, r_busy && (r_pc == PC_BCMP), (r_low <= r_high) && (r_high < count_s))

endmodule
`default_nettype wire

/* sim/rotated_sorted_array_search_tb.sv */
`default_nettype none
module rotated_sorted_array_search_tb;
    import rsas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 1024;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 100;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        t_in_beat beat;
        bit       drain;
    } t_stim;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    t_stim     stim_q[$];
    t_out_beat due_results[$];
    int        run_vals[$];

    logic signed [31:0] elem_copy [STORE_DEPTH];
    int                 elem_total = 0;

    int        errors = 0;
    int        sent_cnt = 0;
    int        results_seen = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        idle_cyc = 0;
    bit        drv_calm = 1'b0;
    bit        rx_calm = 1'b0;
    bit        hold_done = 1'b0;
    bit        offer_free;
    t_stim     next_item;

    int                 lo, hi, mid, piv, hit;
    bit                 pivot_done;
    logic signed [31:0] cur, prv, nxt, last;
    t_out_beat          expect_r, want;

    rotated_sorted_array_search #(
        .STORE_DEPTH(STORE_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_beat (out_beat)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int bisect_for(input int lo_i, input int hi_i,
                                      input logic signed [31:0] key);
        int l;
        int h;
        int m;
        l = lo_i;
        h = hi_i;
        while (l <= h) begin
            m = l + (h - l) / 2;
            if (elem_copy[m] == key)
                return m;
            if (elem_copy[m] < key)
                l = m + 1;
            else
                h = m - 1;
        end
        return -1;
    endfunction

    task automatic push_beat(input logic [1:0] cmd, input int val, input int key);
        t_stim s;
        s.drain = 1'b0;
        s.beat.command = cmd;
        s.beat.element_value = val;
        s.beat.search_key = key;
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic push_drain();
        t_stim s;
        s.drain = 1'b1;
        s.beat = '0;
        stim_q.insert(stim_q.size(), s);
    endtask

    // ascending distinct values, then rotated
    task automatic build_rotated(input int n);
        longint step_max;
        longint span;
        longint base;
        longint v;
        int     rot;
        int     sorted_vals[$];
        step_max = ($urandom_range(0, 3) == 0) ? (longint'(1) << 21)
                                               : longint'($urandom_range(1, 64));
        span = step_max * n;
        if ($urandom_range(0, 7) == 0)
            base = -(longint'(1) << 31);
        else
            base = -(longint'(1) << 31) + (longint'($urandom) % ((longint'(1) << 32) - span));
        v = base;
        for (int i = 0; i < n; i++) begin
            sorted_vals.insert(sorted_vals.size(), int'(v));
            v += longint'($urandom_range(1, int'(step_max)));
        end
        rot = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, n - 1);
        run_vals.delete();
        for (int i = 0; i < n; i++)
            run_vals.insert(run_vals.size(), sorted_vals[(i + rot) % n]);
    endtask

    task automatic push_searches(input int count);
        int key;
        int idx;
        repeat (count) begin
            idx = $urandom_range(0, run_vals.size() - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: key = run_vals[idx];
                5, 6:          key = run_vals[idx] + ($urandom_range(0, 1) ? 1 : -1);
                7:             key = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                default:       key = $urandom;
            endcase
            push_beat(CMD_SEARCH, $urandom, key);
        end
    endtask

    // driver and store model
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offer_free = !in_valid;
            if (in_valid && in_ready) begin
                offer_free = 1'b1;
                case (in_beat.command)
                    CMD_APPEND: begin
                        if (elem_total < STORE_DEPTH) begin
                            elem_copy[elem_total] = in_beat.element_value;
                            elem_total++;
                        end
                    end
                    CMD_CLEAR: begin
                        elem_total = 0;
                    end
                    CMD_SEARCH: begin
                        expect_r = '0;
                        if (elem_total == 0) begin
                            expect_r.status = ST_EMPTY;
                        end else begin
                            // rotation point, wrapping neighbours
                            lo = 0;
                            hi = elem_total - 1;
                            piv = 0;
                            pivot_done = 1'b0;
                            while (lo <= hi && !pivot_done) begin
                                mid = lo + (hi - lo) / 2;
                                cur = elem_copy[mid];
                                prv = elem_copy[(mid - 1 + elem_total) % elem_total];
                                nxt = elem_copy[(mid + 1) % elem_total];
                                if (cur < prv && cur < nxt) begin
                                    piv = mid;
                                    pivot_done = 1'b1;
                                end else if (cur >= elem_copy[lo]) begin
                                    lo = mid + 1;
                                end else begin
                                    hi = mid - 1;
                                end
                            end
                            last = elem_copy[elem_total - 1];
                            if (last > in_beat.search_key)
                                hit = bisect_for(piv, elem_total - 1, in_beat.search_key);
                            else if (last < in_beat.search_key)
                                hit = bisect_for(0, piv - 1, in_beat.search_key);
                            else
                                hit = elem_total - 1;
                            if (hit < 0) begin
                                expect_r.status = ST_NOT_FOUND;
                            end else begin
                                expect_r.status = ST_FOUND;
                                expect_r.found_index = hit[IDX_W-1:0];
                            end
                        end
                        due_results.insert(due_results.size(), expect_r);
                    end
                    default: ;
                endcase
                sent_cnt++;
                if (sent_cnt % 40 == 0)
                    drv_calm = ($urandom_range(0, 2) == 0);
                gap_left = drv_calm ? 0 : $urandom_range(0, 12);
            end
            if (offer_free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (stim_q.size() > 0 && stim_q[0].drain) begin
                    if (due_results.size() == 0)
                        void'(stim_q.pop_front());
                    in_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    next_item = stim_q.pop_front();
                    in_beat <= next_item.beat;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: unexpected beat status=%0d index=%0d",
                                 out_beat.status, out_beat.found_index);
                end else begin
                    want = due_results.pop_front();
                    if (out_beat.status !== want.status ||
                        out_beat.found_index !== want.found_index) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: status exp %0d got %0d, index exp %0d got %0d",
                                     want.status, out_beat.status,
                                     want.found_index, out_beat.found_index);
                    end
                end
                results_seen++;
                if (results_seen % 32 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                stall_left = rx_calm ? 0 : $urandom_range(0, 12);
                if (!hold_done && results_seen == 30) begin
                    stall_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int made;
        int n;
        int m;
        int k;
        logic [1:0] cmd;

        // directed
        push_beat(CMD_SEARCH, $urandom, $urandom);
        push_beat(CMD_UNUSED, $urandom, $urandom);
        push_beat(CMD_APPEND, 32'sh80000000, $urandom);
        push_beat(CMD_APPEND, 32'sh7fffffff, $urandom);
        push_beat(CMD_SEARCH, $urandom, 32'sh80000000);
        push_beat(CMD_SEARCH, $urandom, 32'sh7fffffff);
        push_beat(CMD_SEARCH, $urandom, 0);
        push_beat(CMD_CLEAR, $urandom, $urandom);
        push_beat(CMD_SEARCH, $urandom, $urandom);
        push_beat(CMD_APPEND, 100, $urandom);
        push_beat(CMD_APPEND, 32'sh7fffffff, $urandom);
        push_beat(CMD_APPEND, 32'sh80000000, $urandom);
        push_beat(CMD_APPEND, -5, $urandom);
        push_beat(CMD_APPEND, 50, $urandom);
        push_beat(CMD_SEARCH, $urandom, 50);
        push_beat(CMD_SEARCH, $urandom, 32'sh80000000);
        push_beat(CMD_SEARCH, $urandom, 32'sh7fffffff);
        push_beat(CMD_SEARCH, $urandom, 7);
        push_beat(CMD_SEARCH, $urandom, 101);
        push_beat(CMD_CLEAR, $urandom, $urandom);
        push_beat(CMD_APPEND, 42, $urandom);
        push_beat(CMD_SEARCH, $urandom, 42);
        push_beat(CMD_SEARCH, $urandom, 0);
        push_beat(CMD_UNUSED, $urandom, 42);
        push_drain();

        // random sequences and noise
        made = 0;
        while (made < 520) begin
            if ($urandom_range(0, 4) != 0) begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
                if ($urandom_range(0, 5) != 0) begin
                    push_beat(CMD_CLEAR, $urandom, $urandom);
                    made++;
                end
                build_rotated(n);
                foreach (run_vals[i])
                    push_beat(CMD_APPEND, run_vals[i], $urandom);
                made += n;
                m = $urandom_range(2, 8);
                push_searches(m);
                made += m;
                if ($urandom_range(0, 5) == 0)
                    push_drain();
            end else begin
                k = $urandom_range(1, 6);
                repeat (k) begin
                    cmd = 2'($urandom_range(0, 3));
                    push_beat(cmd, $urandom, $urandom);
                    if (cmd != CMD_UNUSED)
                        made++;
                end
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stim_q.size() == 0 && !in_valid && due_results.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && due_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rsas_pkg.sv
hw/rtl/rsas_ram.sv
hw/rtl/rotated_sorted_array_search.sv
sim/rotated_sorted_array_search_tb.sv
